// File: design/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the six-byte utf-8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int BYTE_W      = 8;
  localparam int CP_W        = 31;
  localparam int CAP_W       = 16;
  localparam int LEN_W       = 3;
  localparam int BITS_W      = 7;

  // queue between classifier and decode engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET      = 16'hFFFF;
  localparam logic [CP_W-1:0]  REPLACEMENT_CP = 31'h0000_FFFD;
  localparam logic [LEN_W-1:0] LEN_SATURATED  = 3'd7;

  // lead prefix masks and patterns
  localparam logic [BYTE_W-1:0] PFX_MASK_1 = 8'h80;
  localparam logic [BYTE_W-1:0] PFX_MASK_C = 8'hC0;
  localparam logic [BYTE_W-1:0] PFX_MASK_2 = 8'hE0;
  localparam logic [BYTE_W-1:0] PFX_MASK_3 = 8'hF0;
  localparam logic [BYTE_W-1:0] PFX_MASK_4 = 8'hF8;
  localparam logic [BYTE_W-1:0] PFX_MASK_5 = 8'hFC;
  localparam logic [BYTE_W-1:0] PFX_MASK_6 = 8'hFE;
  localparam logic [BYTE_W-1:0] PFX_CONT   = 8'h80;
  localparam logic [BYTE_W-1:0] PFX_LEAD_2 = 8'hC0;
  localparam logic [BYTE_W-1:0] PFX_LEAD_3 = 8'hE0;
  localparam logic [BYTE_W-1:0] PFX_LEAD_4 = 8'hF0;
  localparam logic [BYTE_W-1:0] PFX_LEAD_5 = 8'hF8;
  localparam logic [BYTE_W-1:0] PFX_LEAD_6 = 8'hFC;

  // payload masks
  localparam logic [BYTE_W-1:0] PAY_MASK_1    = 8'h7F;
  localparam logic [BYTE_W-1:0] PAY_MASK_2    = 8'h1F;
  localparam logic [BYTE_W-1:0] PAY_MASK_3    = 8'h0F;
  localparam logic [BYTE_W-1:0] PAY_MASK_4    = 8'h07;
  localparam logic [BYTE_W-1:0] PAY_MASK_5    = 8'h03;
  localparam logic [BYTE_W-1:0] PAY_MASK_6    = 8'h01;
  localparam logic [BYTE_W-1:0] PAY_MASK_CONT = 8'h3F;

  typedef enum logic [1:0] {
    TOK_CONT,
    TOK_LEAD,
    TOK_BAD_LEAD,
    TOK_TERM
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t              kind;
    logic [LEN_W-1:0]       len;
    logic [BITS_W-1:0]      bits;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } queue_head_t;

  typedef struct packed {
    logic             valid;
    logic [CAP_W-1:0] data;
  } cfg_write_t;

endpackage

// File: design/utf8d_if.sv
// ----------------------------------------------------------------------------
// utf8d interfaces
// byte, code point and configuration channels of the decoder
// ----------------------------------------------------------------------------
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic        is_replacement;
  logic        last;

  modport source (output valid, output code_point, output is_replacement,
                  output last, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last, output ready);
endinterface

interface utf8d_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] output_capacity;

  modport source (output valid, output output_capacity, input ready);
  modport sink   (input valid, input output_capacity, output ready);
endinterface

// File: design/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// byte classifier and the short token queue in front of the decode engine
// ----------------------------------------------------------------------------
module utf8d_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [utf8d_pkg::BYTE_W-1:0] in_byte,
  output logic                         in_ready,
  output utf8d_pkg::queue_head_t       head,
  input  logic                         pop
);

  utf8d_pkg::token_t                 tok;
  utf8d_pkg::token_t                 mem [utf8d_pkg::QUEUE_DEPTH];
  logic [utf8d_pkg::QPTR_W-1:0]      wr_ptr;
  logic [utf8d_pkg::QPTR_W-1:0]      rd_ptr;
  logic [utf8d_pkg::QCNT_W-1:0]      count;
  logic                              push;
  logic                              do_pop;
  logic [utf8d_pkg::BYTE_W-1:0]      masked;

  // classify one byte into a token
  always_comb begin
    tok    = '0;
    masked = '0;
    if (in_byte == '0) begin
      tok.kind = utf8d_pkg::TOK_TERM;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_1) == '0) begin
      tok.kind = utf8d_pkg::TOK_LEAD;
      tok.len  = 3'd1;
      masked   = in_byte & utf8d_pkg::PAY_MASK_1;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_C) == utf8d_pkg::PFX_CONT) begin
      tok.kind = utf8d_pkg::TOK_CONT;
      masked   = in_byte & utf8d_pkg::PAY_MASK_CONT;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_2) == utf8d_pkg::PFX_LEAD_2) begin
      tok.kind = utf8d_pkg::TOK_LEAD;
      tok.len  = 3'd2;
      masked   = in_byte & utf8d_pkg::PAY_MASK_2;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_3) == utf8d_pkg::PFX_LEAD_3) begin
      tok.kind = utf8d_pkg::TOK_LEAD;
      tok.len  = 3'd3;
      masked   = in_byte & utf8d_pkg::PAY_MASK_3;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_4) == utf8d_pkg::PFX_LEAD_4) begin
      tok.kind = utf8d_pkg::TOK_LEAD;
      tok.len  = 3'd4;
      masked   = in_byte & utf8d_pkg::PAY_MASK_4;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_5) == utf8d_pkg::PFX_LEAD_5) begin
      tok.kind = utf8d_pkg::TOK_LEAD;
      tok.len  = 3'd5;
      masked   = in_byte & utf8d_pkg::PAY_MASK_5;
    end else if ((in_byte & utf8d_pkg::PFX_MASK_6) == utf8d_pkg::PFX_LEAD_6) begin
      tok.kind = utf8d_pkg::TOK_LEAD;
      tok.len  = 3'd6;
      masked   = in_byte & utf8d_pkg::PAY_MASK_6;
    end else begin
      tok.kind = utf8d_pkg::TOK_BAD_LEAD;
    end
    tok.bits = masked[utf8d_pkg::BITS_W-1:0];
  end

  assign in_ready   = (count != utf8d_pkg::QCNT_W'(utf8d_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head.valid = (count != '0);
  assign head.tok   = mem[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// group tracking, capacity limit and the output register
// ----------------------------------------------------------------------------
module utf8d_back (
  input  logic                        clk,
  input  logic                        rst,
  input  utf8d_pkg::cfg_write_t       cfg_wr,
  input  utf8d_pkg::queue_head_t      head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8d_pkg::CP_W-1:0]  out_cp,
  output logic                        out_rep,
  output logic                        out_last
);

  logic [utf8d_pkg::CAP_W-1:0] capacity;
  logic                        group_open, group_open_next;
  logic                        lead_invalid, lead_invalid_next;
  logic [utf8d_pkg::LEN_W-1:0] expected_length, expected_length_next;
  logic [utf8d_pkg::LEN_W-1:0] group_length, group_length_next;
  logic [utf8d_pkg::CP_W-1:0]  acc, acc_next;
  logic [utf8d_pkg::CAP_W-1:0] emitted_count, emitted_count_next;

  logic                        can_load;
  logic                        grp_emit;
  logic                        grp_ok;
  logic                        load;
  logic [utf8d_pkg::CP_W-1:0]  load_cp;
  logic                        load_rep;
  logic                        load_last;
  utf8d_pkg::token_t           tok;

  assign tok      = head.tok;
  assign can_load = !out_valid || out_ready;
  assign grp_emit = group_open && (emitted_count < capacity);
  assign grp_ok   = !lead_invalid && (group_length == expected_length);

  always_comb begin
    pop                  = 1'b0;
    load                 = 1'b0;
    load_cp              = grp_ok ? acc : utf8d_pkg::REPLACEMENT_CP;
    load_rep             = !grp_ok;
    load_last            = 1'b0;
    group_open_next      = group_open;
    lead_invalid_next    = lead_invalid;
    expected_length_next = expected_length;
    group_length_next    = group_length;
    acc_next             = acc;
    emitted_count_next   = emitted_count;
    if (head.valid) begin
      case (tok.kind)
        utf8d_pkg::TOK_CONT: begin
          pop = 1'b1;
          if (group_open) begin
            if (group_length != utf8d_pkg::LEN_SATURATED) begin
              group_length_next = group_length + 1'b1;
            end
            acc_next = {acc[utf8d_pkg::CP_W-7:0], tok.bits[5:0]};
          end
        end
        utf8d_pkg::TOK_LEAD, utf8d_pkg::TOK_BAD_LEAD: begin
          if (!grp_emit || can_load) begin
            pop  = 1'b1;
            load = grp_emit;
            if (grp_emit) begin
              emitted_count_next = emitted_count + 1'b1;
            end
            group_open_next   = 1'b1;
            group_length_next = 3'd1;
            if (tok.kind == utf8d_pkg::TOK_BAD_LEAD) begin
              lead_invalid_next    = 1'b1;
              expected_length_next = '0;
              acc_next             = '0;
            end else begin
              lead_invalid_next    = 1'b0;
              expected_length_next = tok.len;
              acc_next = {{(utf8d_pkg::CP_W-utf8d_pkg::BITS_W){1'b0}}, tok.bits};
            end
          end
        end
        utf8d_pkg::TOK_TERM: begin
          if (can_load) begin
            load = 1'b1;
            // a pending group goes out first, and the end marker follows once the output register can take it
            group_open_next      = 1'b0;
            lead_invalid_next    = 1'b0;
            expected_length_next = '0;
            group_length_next    = '0;
            acc_next             = '0;
            if (grp_emit) begin
              emitted_count_next = emitted_count + 1'b1;
            end else begin
              pop                = 1'b1;
              load_cp            = '0;
              load_rep           = 1'b0;
              load_last          = 1'b1;
              emitted_count_next = '0;
            end
          end
        end
        default: begin
          pop = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= utf8d_pkg::CAP_RESET;
      group_open      <= 1'b0;
      lead_invalid    <= 1'b0;
      expected_length <= '0;
      group_length    <= '0;
      acc             <= '0;
      emitted_count   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_wr.valid) begin
        capacity <= cfg_wr.data;
      end
      group_open      <= group_open_next;
      lead_invalid    <= lead_invalid_next;
      expected_length <= expected_length_next;
      group_length    <= group_length_next;
      acc             <= acc_next;
      emitted_count   <= emitted_count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cp   <= load_cp;
      out_rep  <= load_rep;
      out_last <= load_last;
    end
  end

endmodule

// File: design/utf8_six_byte_decoder.sv
// ----------------------------------------------------------------------------
// utf8_six_byte_decoder
// streaming decoder for utf-8 text with the original one to six byte leads
// ----------------------------------------------------------------------------
// takes one byte per cycle unless stalled and gives one code point item per
// finished group; a group finishes when the next lead byte or the zero
// terminator arrives, so each code point appears one lead later than its last
// byte. a terminator always gives an end marker item (code point 0, last set),
// preceded by the result of any open group. bad groups give U+FFFD with
// is_replacement set, stray continuation bytes are dropped, and at most
// output_capacity code points are given per string. the sustained rate is one
// byte per cycle unless the output stalls; a terminator closing a group with a
// result gives two items, as the single output register carries one per cycle.
// a two-entry queue buffers bytes while the result side stalls. the user
// writes configuration only while the decoder is idle; no check enforces it.
module utf8_six_byte_decoder (
  input  logic        clk,
  input  logic        rst,
  utf8d_byte_if.sink  bytes,
  utf8d_cp_if.source  chars,
  utf8d_cfg_if.sink   cfg
);

  // head of the token queue and the pop strobe from the decode engine
  utf8d_pkg::queue_head_t head;
  logic                   pop;
  utf8d_pkg::cfg_write_t  cfg_wr;

  // capacity register is always writable
  assign cfg.ready   = 1'b1;
  assign cfg_wr.valid = cfg.valid;
  assign cfg_wr.data  = cfg.output_capacity;

  // front: classify bytes into lead, continuation, bad lead or terminator
  utf8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bytes.valid),
    .in_byte  (bytes.data_byte),
    .in_ready (bytes.ready),
    .head     (head),
    .pop      (pop)
  );

  // back: collect groups, apply the capacity limit, drive the output item
  utf8d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .head      (head),
    .pop       (pop),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_cp    (chars.code_point),
    .out_rep   (chars.is_replacement),
    .out_last  (chars.last)
  );

endmodule

// File: design/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// port-level checks on the decoder output
// ----------------------------------------------------------------------------
module utf8d_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] code_point,
  input logic        is_replacement,
  input logic        last
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) &&
    $stable(is_replacement) && $stable(last))
    else $error("output item changed while stalled");

  // end marker carries code point zero and no replacement
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (code_point == '0) && !is_replacement)
    else $error("malformed end marker");

  // replacement items carry U+FFFD
  a_rep: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_replacement |-> (code_point == utf8d_pkg::REPLACEMENT_CP) && !last)
    else $error("replacement item with wrong code point");

  // no item right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_six_byte_decoder utf8d_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (chars.valid),
  .out_ready      (chars.ready),
  .code_point     (chars.code_point),
  .is_replacement (chars.is_replacement),
  .last           (chars.last)
);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the six-byte utf-8 decoder: a directed table of
// byte items, then phases of random strings at several capacities, every code point
// item checked in order against typed rows or a byte-level decode model
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int BYTE_W = utf8d_pkg::BYTE_W;
  localparam int CP_W   = utf8d_pkg::CP_W;
  localparam int CAP_W  = utf8d_pkg::CAP_W;
  localparam int LEN_W  = utf8d_pkg::LEN_W;

  // one code point item as it leaves the decoder
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            is_replacement;
    logic            last;
  } char_item_t;

  // one byte item of stimulus; typed rows carry their code point items
  // written out by hand, the rest are left to the decode model
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              typed;
    logic [1:0]        n_typed;
    char_item_t        first;
    char_item_t        second;
  } stim_row_t;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int LONG_HOLD     = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASE_BYTES   = 120;
  localparam int NUM_PHASES    = 6;

  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;
  localparam logic [BYTE_W-1:0] BAD_LEAD_FE = 8'hFE;

  localparam char_item_t NO_CHAR   = '0;
  localparam char_item_t END_MARK  = '{code_point: '0, is_replacement: 1'b0, last: 1'b1};
  localparam char_item_t BAD_GROUP = '{code_point: utf8d_pkg::REPLACEMENT_CP,
                                       is_replacement: 1'b1, last: 1'b0};

  logic clk;
  logic rst;

  utf8d_byte_if byte_ch ();
  utf8d_cp_if   char_ch ();
  utf8d_cfg_if  cfg_ch ();

  utf8_six_byte_decoder dut (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_ch),
    .chars (char_ch),
    .cfg   (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  // walks every lead form, both invalid leads, a stray continuation after
  // reset, a short and a long group, the largest 31-bit code point, an
  // overlong zero and a terminator that closes an open group (two items)
  stim_row_t directed_rows [27] = '{
    '{8'h00, 1'b1, 2'd1, END_MARK, NO_CHAR},                       // terminator after reset
    '{8'h80, 1'b1, 2'd0, NO_CHAR, NO_CHAR},                        // stray continuation
    '{8'h7F, 1'b1, 2'd0, NO_CHAR, NO_CHAR},                        // largest one-byte lead
    '{8'hFE, 1'b1, 2'd1, '{31'h7F, 1'b0, 1'b0}, NO_CHAR},          // closes 7f
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hFF, 1'b1, 2'd1, BAD_GROUP, NO_CHAR},                      // fe group is bad
    '{8'hFD, 1'b1, 2'd1, BAD_GROUP, NO_CHAR},                      // ff group is bad
    '{8'hBF, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hBF, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hBF, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hBF, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hBF, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hC0, 1'b1, 2'd1, '{31'h7FFF_FFFF, 1'b0, 1'b0}, NO_CHAR},   // all 31 bits set
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hE0, 1'b0, 2'd0, NO_CHAR, NO_CHAR},                        // overlong zero
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hF0, 1'b1, 2'd1, BAD_GROUP, NO_CHAR},                      // three-byte lead, short
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'hF8, 1'b1, 2'd1, BAD_GROUP, NO_CHAR},                      // four-byte lead, long
    '{8'h88, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h80, 1'b0, 2'd0, NO_CHAR, NO_CHAR},
    '{8'h00, 1'b0, 2'd0, NO_CHAR, NO_CHAR}                         // five-byte group, then end
  };

  // --------------------------------------------------------------------------
  // decode model state
  // --------------------------------------------------------------------------
  logic [CAP_W-1:0]  cap_setting;
  logic              grp_open;
  logic              grp_bad_lead;
  logic [LEN_W-1:0]  grp_want;
  logic [LEN_W-1:0]  grp_len;
  logic [CP_W-1:0]   grp_bits;
  logic [CAP_W-1:0]  chars_given;

  char_item_t step_out [$];        // items caused by the byte just decoded
  char_item_t expected_chars [$];  // items still owed by the decoder
  stim_row_t  byte_plan [$];       // byte items waiting to be offered

  int          mismatch_count;
  int          cycles_run;
  logic        src_idle_on;
  logic        snk_idle_on;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned sink_wait;
  logic [CAP_W-1:0] phase_caps [NUM_PHASES];

  // sort a byte into terminator, continuation, valid lead or invalid lead
  function automatic utf8d_pkg::tok_kind_t byte_kind(input logic [BYTE_W-1:0] b,
                                                     output logic [LEN_W-1:0] len,
                                                     output logic [CP_W-1:0] payload);
    len = '0;
    payload = '0;
    if (b == TERMINATOR) return utf8d_pkg::TOK_TERM;
    if ((b & utf8d_pkg::PFX_MASK_1) == '0) begin
      len = 3'd1;
      payload = CP_W'(b & utf8d_pkg::PAY_MASK_1);
      return utf8d_pkg::TOK_LEAD;
    end
    if ((b & utf8d_pkg::PFX_MASK_C) == utf8d_pkg::PFX_CONT) return utf8d_pkg::TOK_CONT;
    if ((b & utf8d_pkg::PFX_MASK_2) == utf8d_pkg::PFX_LEAD_2) begin
      len = 3'd2;
      payload = CP_W'(b & utf8d_pkg::PAY_MASK_2);
      return utf8d_pkg::TOK_LEAD;
    end
    if ((b & utf8d_pkg::PFX_MASK_3) == utf8d_pkg::PFX_LEAD_3) begin
      len = 3'd3;
      payload = CP_W'(b & utf8d_pkg::PAY_MASK_3);
      return utf8d_pkg::TOK_LEAD;
    end
    if ((b & utf8d_pkg::PFX_MASK_4) == utf8d_pkg::PFX_LEAD_4) begin
      len = 3'd4;
      payload = CP_W'(b & utf8d_pkg::PAY_MASK_4);
      return utf8d_pkg::TOK_LEAD;
    end
    if ((b & utf8d_pkg::PFX_MASK_5) == utf8d_pkg::PFX_LEAD_5) begin
      len = 3'd5;
      payload = CP_W'(b & utf8d_pkg::PAY_MASK_5);
      return utf8d_pkg::TOK_LEAD;
    end
    if ((b & utf8d_pkg::PFX_MASK_6) == utf8d_pkg::PFX_LEAD_6) begin
      len = 3'd6;
      payload = CP_W'(b & utf8d_pkg::PAY_MASK_6);
      return utf8d_pkg::TOK_LEAD;
    end
    return utf8d_pkg::TOK_BAD_LEAD;
  endfunction

  // the open group gives its item unless the string is already at capacity
  function automatic void close_group();
    if (grp_open && chars_given < cap_setting) begin
      if (!grp_bad_lead && grp_len == grp_want)
        step_out.push_back('{code_point: grp_bits, is_replacement: 1'b0, last: 1'b0});
      else
        step_out.push_back(BAD_GROUP);
      chars_given = chars_given + 1'b1;
    end
  endfunction

  // advance the model by one accepted byte; results land in step_out
  function automatic void decode_byte(input logic [BYTE_W-1:0] b);
    utf8d_pkg::tok_kind_t kind;
    logic [LEN_W-1:0]     lead_len;
    logic [CP_W-1:0]      payload;
    step_out.delete();
    kind = byte_kind(b, lead_len, payload);
    case (kind)
      utf8d_pkg::TOK_TERM: begin
        // group item first, then the end marker, then a fresh string
        close_group();
        step_out.push_back(END_MARK);
        grp_open = 1'b0;
        grp_bad_lead = 1'b0;
        grp_want = '0;
        grp_len = '0;
        grp_bits = '0;
        chars_given = '0;
      end
      utf8d_pkg::TOK_CONT: begin
        // stray continuation bytes fall through untouched
        if (grp_open) begin
          if (grp_len != utf8d_pkg::LEN_SATURATED) grp_len = grp_len + 1'b1;
          grp_bits = {grp_bits[CP_W-7:0], b[5:0]};
        end
      end
      default: begin
        close_group();
        grp_open = 1'b1;
        grp_len = 3'd1;
        grp_bad_lead = (kind == utf8d_pkg::TOK_BAD_LEAD);
        grp_want = lead_len;
        grp_bits = payload;
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // random stimulus
  // --------------------------------------------------------------------------
  // idle length: mostly none, often short, now and then long
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b);
    byte_plan.push_back('{b, 1'b0, 2'd0, NO_CHAR, NO_CHAR});
  endfunction

  function automatic logic [BYTE_W-1:0] random_cont();
    logic [BYTE_W-1:0] r;
    r = BYTE_W'($urandom_range(0, 255));
    return utf8d_pkg::PFX_CONT | (r & utf8d_pkg::PAY_MASK_CONT);
  endfunction

  // lead byte of the given length with random payload bits
  function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned len);
    logic [BYTE_W-1:0] r;
    r = BYTE_W'($urandom_range(0, 255));
    case (len)
      1: return r & utf8d_pkg::PAY_MASK_1;
      2: return utf8d_pkg::PFX_LEAD_2 | (r & utf8d_pkg::PAY_MASK_2);
      3: return utf8d_pkg::PFX_LEAD_3 | (r & utf8d_pkg::PAY_MASK_3);
      4: return utf8d_pkg::PFX_LEAD_4 | (r & utf8d_pkg::PAY_MASK_4);
      5: return utf8d_pkg::PFX_LEAD_5 | (r & utf8d_pkg::PAY_MASK_5);
      default: return utf8d_pkg::PFX_LEAD_6 | (r & utf8d_pkg::PAY_MASK_6);
    endcase
  endfunction

  // one character: mostly well formed, the rest short, long, badly led,
  // stray continuations or a raw random byte
  function automatic void add_char();
    int unsigned p;
    int unsigned len;
    int unsigned n_cont;
    p = $urandom_range(0, 99);
    len = $urandom_range(1, 6);
    if (p < 78) begin
      n_cont = len - 1;
      push_byte(lead_byte(len));
    end else if (p < 83) begin
      n_cont = (len > 1) ? $urandom_range(0, len - 2) : 0;
      push_byte(lead_byte(len));
    end else if (p < 88) begin
      // long enough at times to saturate the group length
      n_cont = len - 1 + $urandom_range(1, 8);
      push_byte(lead_byte(len));
    end else if (p < 92) begin
      n_cont = $urandom_range(0, 6);
      push_byte(BAD_LEAD_FE | BYTE_W'($urandom_range(0, 1)));
    end else if (p < 96) begin
      n_cont = $urandom_range(1, 3);
    end else begin
      n_cont = 0;
      push_byte(BYTE_W'($urandom_range(0, 255)));
    end
    repeat (n_cont) push_byte(random_cont());
  endfunction

  // a string of a few characters, sometimes long enough to hit capacity
  function automatic void add_string(input bit terminate);
    int unsigned n_chars;
    n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
    // continuation bytes straight after a terminator have no group to join
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(random_cont());
    repeat (n_chars) add_char();
    if (terminate) push_byte(TERMINATOR);
  endfunction

  // --------------------------------------------------------------------------
  // byte side
  // --------------------------------------------------------------------------
  // offers the planned items in order; valid stays up across back-to-back
  // items and the model advances at the edge where an item is taken
  task automatic offer_all();
    stim_row_t   row;
    int unsigned gap;
    while (byte_plan.size() != 0) begin
      row = byte_plan.pop_front();
      byte_ch.data_byte <= row.data;
      byte_ch.valid <= 1'b1;
      @(posedge clk);
      while (!byte_ch.ready) @(posedge clk);
      decode_byte(row.data);
      if (row.typed) begin
        if (row.n_typed > 0) expected_chars.push_back(row.first);
        if (row.n_typed > 1) expected_chars.push_back(row.second);
      end else begin
        foreach (step_out[i]) expected_chars.push_back(step_out[i]);
      end
      gap = src_idle_on ? idle_len() : 0;
      if (gap != 0 || byte_plan.size() == 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // capacity changes only with the decoder quiet; a trailing group can still
  // be in flight with nothing owed, hence the settle time
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.output_capacity <= cap;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cap_setting = cap;
  endtask

  // --------------------------------------------------------------------------
  // code point side
  // --------------------------------------------------------------------------
  // random stalls, plus a long hold on request so the decoder backs up and
  // pushes back on the byte side
  always @(posedge clk) begin
    if (rst) begin
      char_ch.ready <= 1'b0;
      sink_wait <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      char_ch.ready <= 1'b0;
      sink_wait <= LONG_HOLD;
    end else if (sink_wait != 0) begin
      char_ch.ready <= 1'b0;
      sink_wait <= sink_wait - 1;
    end else begin
      char_ch.ready <= 1'b1;
      sink_wait <= snk_idle_on ? idle_len() : 0;
    end
  end

  function automatic void check_field(input string name, input logic [CP_W-1:0] want,
                                      input logic [CP_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // every item taken is held against the oldest one owed
  always @(posedge clk) begin
    char_item_t want;
    if (!rst && char_ch.valid && char_ch.ready) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        $error("code_point item %0h with nothing expected", char_ch.code_point);
      end else begin
        want = expected_chars.pop_front();
        check_field("code_point", want.code_point, char_ch.code_point);
        check_field("is_replacement", CP_W'(want.is_replacement), CP_W'(char_ch.is_replacement));
        check_field("last", CP_W'(want.last), CP_W'(char_ch.last));
      end
    end
  end

  // watchdog
  initial begin
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.output_capacity = '0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    hold_requests = 0;
    mismatch_count = 0;
    cap_setting = utf8d_pkg::CAP_RESET;
    grp_open = 1'b0;
    grp_bad_lead = 1'b0;
    grp_want = '0;
    grp_len = '0;
    grp_bits = '0;
    chars_given = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed table at full capacity
    write_capacity(utf8d_pkg::CAP_RESET);
    foreach (directed_rows[i]) byte_plan.push_back(directed_rows[i]);
    offer_all();

    // capacity per phase: full, none, one, three, a random few, full again;
    // phases end mid string, so a lower capacity can land below the count
    phase_caps = '{16'hFFFF, 16'd0, 16'd1, 16'd3, 16'd5, 16'hFFFF};
    phase_caps[4] = CAP_W'($urandom_range(2, 8));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      // phase 0 runs the byte side flat out into a long hold, phase 3 idles
      // on neither side
      src_idle_on = (ph != 0 && ph != 3);
      snk_idle_on <= (ph != 3);
      if (ph == 0) hold_requests <= hold_requests + 1;
      while (byte_plan.size() < PHASE_BYTES) add_string(1'b1);
      add_string(1'b0);
      offer_all();
    end

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
